@@ design/rcm_pkg.sv @@
`default_nettype none

package rcm_pkg;

  // Default parameter values of the top level.
  localparam int SCREEN_W  = 64;
  localparam int SCREEN_H  = 32;
  localparam int MAP_SIZE  = 16;
  localparam int MAX_STEPS = 255;

  // Fixed field widths.
  localparam int COL_W  = 6;
  localparam int STEP_W = 8;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 16;
  localparam int ANG_W  = 12;

  // Trig table: Q1.14 quarter wave, entries 0 to 1024 inclusive.
  localparam int TRIG_W  = 16;
  localparam int SINE_W  = 15;
  localparam int SINE_N  = 1025;
  localparam int SINE_AW = 11;

  // Sample positions are kept as cell index plus remainder in units of 1/POS_UNIT cell.
  localparam int POS_UNIT  = 163840;
  localparam int POS_SCALE = 40;
  localparam int FRAC_W    = 18;
  localparam int POS_FRAC  = 12;

  // APB configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_PLAYER_X     = 2'd0;
  localparam logic [1:0] REG_PLAYER_Y     = 2'd1;
  localparam logic [1:0] REG_PLAYER_ANGLE = 2'd2;
  localparam logic [1:0] REG_FOV          = 2'd3;

  localparam logic [POS_W-1:0] PLAYER_X_RST = 16'd32768;
  localparam logic [POS_W-1:0] PLAYER_Y_RST = 16'd32768;
  localparam logic [ANG_W-1:0] ANGLE_RST    = 12'd0;
  localparam logic [ANG_W-1:0] FOV_RST      = 12'd683;

  // Fixed maze: bit x of row y is a wall. Cells outside it are walls.
  localparam int MAZE_N  = 16;
  localparam int ROW_MAX = 64;
  localparam logic [MAZE_N-1:0] MAZE_ROWS [MAZE_N] = '{
    16'hFFFF, 16'h8001, 16'h8001, 16'h8061, 16'h8061, 16'h8001, 16'h8001, 16'h8181,
    16'h8181, 16'h8001, 16'h8001, 16'h8221, 16'h8221, 16'h8001, 16'h8001, 16'hFFFF
  };

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_N];

  // One map row of up to ROW_MAX cells, walls outside the fixed maze.
  function automatic logic [ROW_MAX-1:0] maze_row(int y);
    logic [ROW_MAX-1:0] row;
    row = '1;
    for (int x = 0; x < ROW_MAX; x++) begin
      if (x < MAZE_N && y < MAZE_N) begin
        row[x] = MAZE_ROWS[y][x];
      end
    end
    return row;
  endfunction

  // sin(k*pi/2048) in Q1.14 by a Taylor series in Q30, rounded to nearest.
  function automatic logic [SINE_W-1:0] series_sine(int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint unsigned rounded;
    x    = (64'(k) * PI_Q30) / 64'd2048;
    x2   = (x * x) >> 30;
    term = x;
    sum  = 0;
    for (int i = 0; i < 14; i++) begin
      if (i % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
      term = (term * x2) >> 30;
      term = term / 64'((2 * i + 2) * (2 * i + 3));
    end
    if (sum < 0) begin
      sum = 0;
    end
    rounded = (longint'(sum) + 64'd32768) >> 16;
    return rounded[SINE_W-1:0];
  endfunction

  // Whole quarter-wave table, evaluated at elaboration.
  function automatic sine_tab_t sine_table();
    sine_tab_t t;
    for (int k = 0; k < SINE_N; k++) begin
      t[k] = series_sine(k);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ design/rcm_if.sv @@
`default_nettype none

// Column request channel.
interface rcm_in_if;
  logic                      valid;
  logic                      ready;
  logic [rcm_pkg::COL_W-1:0] column;

  modport source (output valid, output column, input ready);
  modport sink   (input valid, input column, output ready);
endinterface

// Column result channel.
interface rcm_out_if;
  logic                       valid;
  logic                       ready;
  logic [rcm_pkg::COL_W-1:0]  column_out;
  logic [rcm_pkg::STEP_W-1:0] step_count;
  logic [rcm_pkg::ROW_W-1:0]  slice_top;
  logic [rcm_pkg::ROW_W-1:0]  slice_bottom;
  logic                       no_hit;

  modport source (output valid, output column_out, output step_count, output slice_top,
                  output slice_bottom, output no_hit, input ready);
  modport sink   (input valid, input column_out, input step_count, input slice_top,
                  input slice_bottom, input no_hit, output ready);
endinterface

`default_nettype wire

@@ design/rcm_ram.sv @@
`default_nettype none

// Single-port-write, single-port-read RAM with a registered read.
module rcm_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/raycast_column_marcher.sv @@
`default_nettype none

// Ray caster for one screen column per transaction.
// A transaction on col_i carries a column index. The block casts a ray from the
// player position at angle player_angle - fov/2 + column*fov/ScreenW and returns
// one transaction on res_o with the step count to the first wall (or to the end
// of the march on a miss), the wall slice rows and a no_hit flag. The user must
// write player position, angle and field of view through the APB port only while
// no column is in flight; the block itself does not enforce this. Per column the
// block computes the ray angle, reads the trig table twice, marches against the map
// memory and, when a wall is hit, runs a bit-serial divide of the DvdW-bit dividend
// for the wall height, then loads the result. The next column is accepted in the
// cycle after the result is loaded, so no new column is taken before the last one
// is through; the march runs at one step per cycle. The result register frees the
// block even while its result waits for res_o.ready.
// After reset the map memory is loaded with the maze, one row a cycle, before the
// first column is accepted. A stalled receiver holds the result and, once a second
// result is ready, holds the block.
module raycast_column_marcher #(
  parameter int ScreenW  = rcm_pkg::SCREEN_W,
  parameter int ScreenH  = rcm_pkg::SCREEN_H,
  parameter int MapSize  = rcm_pkg::MAP_SIZE,
  parameter int MaxSteps = rcm_pkg::MAX_STEPS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rcm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rcm_pkg::PDATA_W-1:0] pwdata,
  output      logic [rcm_pkg::PDATA_W-1:0] prdata,
  output      logic                        pready,
  rcm_in_if.sink                           col_i,
  rcm_out_if.source                        res_o
);

  localparam int AddrW  = $clog2(MapSize);
  localparam int CellW  = $clog2((MapSize > rcm_pkg::MAZE_N ? MapSize : rcm_pkg::MAZE_N) + 1) + 1;
  localparam int NW     = $clog2(MaxSteps + 1);
  localparam int HNum   = 5 * ScreenH;
  localparam int HW     = $clog2(HNum + 1);
  localparam int ProdW  = rcm_pkg::COL_W + rcm_pkg::ANG_W;
  localparam int DvdW   = ProdW > HW ? ProdW : HW;
  localparam int DvsW   = NW;
  localparam int CntW   = $clog2(DvdW);
  localparam int DrawW  = HW + 2;
  localparam int HalfH  = ScreenH / 2;
  localparam int FracW  = rcm_pkg::FRAC_W;
  localparam int TrigW  = rcm_pkg::TRIG_W;
  localparam int AngW   = rcm_pkg::ANG_W;
  localparam int QuarterW = AngW - 2;

  // Reciprocal of the screen width, exact for every column and field of view product.
  localparam int RecipSh = ProdW + $clog2(ScreenW);
  localparam int RpW     = RecipSh + ProdW;
  localparam longint unsigned RecipM =
    ((64'd1 << RecipSh) + 64'(ScreenW) - 64'd1) / 64'(ScreenW);

  localparam logic signed [CellW-1:0] MapLim  = CellW'(MapSize);
  localparam logic signed [FracW:0]   PosUnit = (FracW + 1)'(rcm_pkg::POS_UNIT);
  localparam rcm_pkg::sine_tab_t      SineRom = rcm_pkg::sine_table();

  typedef enum logic [7:0] {
    S_FILL   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_ANGLE  = 8'b0000_1000,
    S_TRIG   = 8'b0001_0000,
    S_SETUP  = 8'b0010_0000,
    S_MARCH  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  // Control registers.
  state_e                   state_q, state_d;
  logic [AddrW-1:0]         fill_q, fill_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     hit_q, hit_d;
  logic                     chk_v_q, chk_v_d;
  logic                     out_valid_q, out_valid_d;
  logic [rcm_pkg::POS_W-1:0] player_x_q, player_y_q;
  logic [AngW-1:0]          player_angle_q, fov_q;

  // Datapath registers.
  logic [rcm_pkg::COL_W-1:0] col_q, col_d;
  logic [DvdW-1:0]           quo_q, quo_d;
  logic [DvsW-1:0]           rem_q, rem_d;
  logic [DvsW-1:0]           dvs_q, dvs_d;
  logic [AngW-1:0]           ang_q, ang_d;
  logic [rcm_pkg::SINE_W-1:0] sa_q, sa_d;
  logic [rcm_pkg::SINE_W-1:0] rom_q;
  logic [rcm_pkg::SINE_AW-1:0] rom_addr;
  logic signed [TrigW-1:0]   c_q, c_d, s_q, s_d;
  logic signed [CellW-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic [FracW-1:0]          fx_q, fx_d, fy_q, fy_d;
  logic [NW-1:0]             n_q, n_d;
  logic [NW-1:0]             steps_q, steps_d;
  logic signed [CellW-1:0]   chk_cx_q, chk_cx_d;
  logic [NW-1:0]             chk_n_q, chk_n_d;
  logic [rcm_pkg::COL_W-1:0] out_col_q, out_col_d;
  logic [rcm_pkg::STEP_W-1:0] out_step_q, out_step_d;
  logic [rcm_pkg::ROW_W-1:0] out_start_q, out_start_d;
  logic [rcm_pkg::ROW_W-1:0] out_end_q, out_end_d;
  logic                      out_nohit_q, out_nohit_d;

  // Map memory signals.
  logic                      ram_we;
  logic [AddrW-1:0]          ram_raddr;
  logic [MapSize-1:0]        ram_rdata;
  logic [rcm_pkg::ROW_MAX-1:0] maze_full;

  // Combinational helpers.
  logic                      cfg_wr;
  logic                      in_fire;
  logic [ProdW-1:0]          prod;
  logic [RpW-1:0]            recip_prod;
  logic [AngW-1:0]           ang_quo;
  logic [DvsW:0]             div_shift;
  logic                      div_bit;
  logic [AngW-1:0]           ang_calc;
  logic signed [TrigW-1:0]   sin_r, sin_c;
  logic signed [FracW:0]     fsum_x, fsum_y;
  logic signed [CellW-1:0]   cx_n, cy_n;
  logic [FracW-1:0]          fx_n, fy_n;
  logic                      in_range;
  logic                      row_bit;
  logic [HW-1:0]             half_h;
  logic signed [DrawW-1:0]   st_raw, en_raw, st_clip, en_clip;
  logic [rcm_pkg::STEP_W-1:0] step_sat;

  // APB configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      rcm_pkg::REG_PLAYER_X:     prdata = rcm_pkg::PDATA_W'(player_x_q);
      rcm_pkg::REG_PLAYER_Y:     prdata = rcm_pkg::PDATA_W'(player_y_q);
      rcm_pkg::REG_PLAYER_ANGLE: prdata = rcm_pkg::PDATA_W'(player_angle_q);
      rcm_pkg::REG_FOV:          prdata = rcm_pkg::PDATA_W'(fov_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q     <= rcm_pkg::PLAYER_X_RST;
      player_y_q     <= rcm_pkg::PLAYER_Y_RST;
      player_angle_q <= rcm_pkg::ANGLE_RST;
      fov_q          <= rcm_pkg::FOV_RST;
    end else if (cfg_wr && pready) begin
      case (paddr[3:2])
        rcm_pkg::REG_PLAYER_X:     player_x_q     <= pwdata[rcm_pkg::POS_W-1:0];
        rcm_pkg::REG_PLAYER_Y:     player_y_q     <= pwdata[rcm_pkg::POS_W-1:0];
        rcm_pkg::REG_PLAYER_ANGLE: player_angle_q <= pwdata[AngW-1:0];
        rcm_pkg::REG_FOV:          fov_q          <= pwdata[AngW-1:0];
        default: ;
      endcase
    end
  end

  // Map memory, loaded with the maze after reset. Reads and writes never overlap:
  // all writes happen during the load pass, before any march.
  assign maze_full = rcm_pkg::maze_row(int'(fill_q));

  rcm_ram #(
    .Width (MapSize),
    .Depth (MapSize)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q),
    .wdata_i (maze_full[MapSize-1:0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sine table with a registered read.
  always_ff @(posedge clk_i) begin
    rom_q <= SineRom[rom_addr];
  end

  // Handshake.
  assign col_i.ready = (state_q == S_IDLE);
  assign in_fire     = col_i.valid && col_i.ready;

  assign res_o.valid        = out_valid_q;
  assign res_o.column_out   = out_col_q;
  assign res_o.step_count   = out_step_q;
  assign res_o.slice_top    = out_start_q;
  assign res_o.slice_bottom = out_end_q;
  assign res_o.no_hit       = out_nohit_q;

  // Restoring divider for the wall height: one quotient bit per cycle.
  assign prod      = ProdW'(col_i.column) * ProdW'(fov_q);
  assign div_shift = {rem_q, quo_q[DvdW-1]};
  assign div_bit   = (div_shift >= {1'b0, dvs_q});

  // Ray angle, wrapping mod one turn. The column offset is divided by the screen
  // width through a multiplication by its reciprocal.
  assign recip_prod = RpW'(quo_q[ProdW-1:0]) * RpW'(RecipM);
  assign ang_quo    = recip_prod[RecipSh +: AngW];
  assign ang_calc   = player_angle_q - (fov_q >> 1) + ang_quo;

  // Table values of the current quadrant: sa_q = sin[r], rom_q = sin[1024 - r].
  assign sin_r = $signed(TrigW'(sa_q));
  assign sin_c = $signed(TrigW'(rom_q));

  // Next sample point: remainder plus trig, with at most one cell carry or borrow.
  assign fsum_x = $signed({1'b0, fx_q}) + (FracW + 1)'(c_q);
  assign fsum_y = $signed({1'b0, fy_q}) + (FracW + 1)'(s_q);

  always_comb begin
    if (fsum_x >= PosUnit) begin
      fx_n = FracW'(fsum_x - PosUnit);
      cx_n = cx_q + CellW'(1);
    end else if (fsum_x < 0) begin
      fx_n = FracW'(fsum_x + PosUnit);
      cx_n = cx_q - CellW'(1);
    end else begin
      fx_n = FracW'(fsum_x);
      cx_n = cx_q;
    end
    if (fsum_y >= PosUnit) begin
      fy_n = FracW'(fsum_y - PosUnit);
      cy_n = cy_q + CellW'(1);
    end else if (fsum_y < 0) begin
      fy_n = FracW'(fsum_y + PosUnit);
      cy_n = cy_q - CellW'(1);
    end else begin
      fy_n = FracW'(fsum_y);
      cy_n = cy_q;
    end
  end

  assign in_range = (cx_n >= 0) && (cx_n < MapLim) && (cy_n >= 0) && (cy_n < MapLim);
  assign row_bit  = ram_rdata[chk_cx_q[AddrW-1:0]];

  // Wall slice rows from the height quotient, clamped to the screen.
  assign half_h  = quo_q[HW-1:0] >> 1;
  assign st_raw  = DrawW'(HalfH) - $signed(DrawW'(half_h));
  assign en_raw  = DrawW'(HalfH) + $signed(DrawW'(half_h));
  assign st_clip = (st_raw < 0) ? '0 : st_raw;
  assign en_clip = (en_raw > DrawW'(ScreenH - 1)) ? DrawW'(ScreenH - 1) : en_raw;
  assign step_sat = (32'(steps_q) > 32'(2 ** rcm_pkg::STEP_W - 1)) ? '1
                                                                     : rcm_pkg::STEP_W'(steps_q);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    chk_v_d     = chk_v_q;
    out_valid_d = out_valid_q;
    col_d       = col_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    ang_d       = ang_q;
    sa_d        = sa_q;
    c_d         = c_q;
    s_d         = s_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    n_d         = n_q;
    steps_d     = steps_q;
    chk_cx_d    = chk_cx_q;
    chk_n_d     = chk_n_q;
    out_col_d   = out_col_q;
    out_step_d  = out_step_q;
    out_start_d = out_start_q;
    out_end_d   = out_end_q;
    out_nohit_d = out_nohit_q;
    ram_we      = 1'b0;
    ram_raddr   = cy_n[AddrW-1:0];
    rom_addr    = '0;

    if (res_o.valid && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_FILL: begin
        ram_we = 1'b1;
        fill_d = fill_q + AddrW'(1);
        if (fill_q == AddrW'(MapSize - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          col_d   = col_i.column;
          quo_d   = DvdW'(prod);
          state_d = S_ANGLE;
        end
      end

      S_DIV: begin
        rem_d = div_bit ? DvsW'(div_shift - {1'b0, dvs_q}) : div_shift[DvsW-1:0];
        quo_d = {quo_q[DvdW-2:0], div_bit};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DvdW - 1)) begin
          state_d = S_FINISH;
        end
      end

      S_ANGLE: begin
        ang_d    = ang_calc;
        rom_addr = rcm_pkg::SINE_AW'(ang_calc[QuarterW-1:0]);
        state_d  = S_TRIG;
      end

      S_TRIG: begin
        sa_d     = rom_q;
        rom_addr = rcm_pkg::SINE_AW'(2 ** QuarterW) - rcm_pkg::SINE_AW'(ang_q[QuarterW-1:0]);
        state_d  = S_SETUP;
      end

      S_SETUP: begin
        case (ang_q[AngW-1:AngW-2])
          2'd0: begin
            s_d = sin_r;
            c_d = sin_c;
          end
          2'd1: begin
            s_d = sin_c;
            c_d = -sin_r;
          end
          2'd2: begin
            s_d = -sin_r;
            c_d = -sin_c;
          end
          default: begin
            s_d = -sin_c;
            c_d = sin_r;
          end
        endcase
        cx_d    = $signed(CellW'(player_x_q[rcm_pkg::POS_W-1:rcm_pkg::POS_FRAC]));
        cy_d    = $signed(CellW'(player_y_q[rcm_pkg::POS_W-1:rcm_pkg::POS_FRAC]));
        fx_d    = FracW'(player_x_q[rcm_pkg::POS_FRAC-1:0]) * FracW'(rcm_pkg::POS_SCALE);
        fy_d    = FracW'(player_y_q[rcm_pkg::POS_FRAC-1:0]) * FracW'(rcm_pkg::POS_SCALE);
        n_d     = '0;
        chk_v_d = 1'b0;
        state_d = S_MARCH;
      end

      // One step a cycle: the row of the previous step is checked while the next
      // step's row is read.
      S_MARCH: begin
        if (chk_v_q && row_bit) begin
          hit_d   = 1'b1;
          steps_d = chk_n_q;
          chk_v_d = 1'b0;
          quo_d   = DvdW'(HNum);
          rem_d   = '0;
          dvs_d   = DvsW'(chk_n_q);
          cnt_d   = '0;
          state_d = S_DIV;
        end else if (n_q == NW'(MaxSteps)) begin
          hit_d   = 1'b0;
          steps_d = n_q;
          chk_v_d = 1'b0;
          state_d = S_FINISH;
        end else if (!in_range) begin
          hit_d   = 1'b0;
          steps_d = n_q + NW'(1);
          chk_v_d = 1'b0;
          state_d = S_FINISH;
        end else begin
          chk_v_d  = 1'b1;
          chk_cx_d = cx_n;
          chk_n_d  = n_q + NW'(1);
          n_d      = n_q + NW'(1);
          cx_d     = cx_n;
          cy_d     = cy_n;
          fx_d     = fx_n;
          fy_d     = fy_n;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_col_d   = col_q;
          out_step_d  = step_sat;
          out_nohit_d = !hit_q;
          out_start_d = hit_q ? st_clip[rcm_pkg::ROW_W-1:0] : '0;
          out_end_d   = hit_q ? en_clip[rcm_pkg::ROW_W-1:0] : '0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      fill_q      <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    col_q       <= col_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    dvs_q       <= dvs_d;
    ang_q       <= ang_d;
    sa_q        <= sa_d;
    c_q         <= c_d;
    s_q         <= s_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    fx_q        <= fx_d;
    fy_q        <= fy_d;
    n_q         <= n_d;
    steps_q     <= steps_d;
    chk_cx_q    <= chk_cx_d;
    chk_n_q     <= chk_n_d;
    out_col_q   <= out_col_d;
    out_step_q  <= out_step_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
    out_nohit_q <= out_nohit_d;
  end

`ifndef SYNTHESIS
  // A pending map check always points at a cell inside the map.
  a_chk_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_v_q |-> (chk_cx_q >= 0 && chk_cx_q < MapLim))
    else $error("map check outside the map");

  // An accepted column starts the ray angle in the next cycle.
  a_accept_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_i.valid && col_i.ready) |=> (state_q == S_ANGLE))
    else $error("accepted column did not start the ray angle");

  // A miss carries an empty slice.
  a_miss_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.no_hit) |-> (res_o.slice_top == '0 && res_o.slice_bottom == '0))
    else $error("miss result with nonzero slice rows");

  // Every march takes at least one step.
  a_steps_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.step_count != '0))
    else $error("result with zero step count");
`endif

endmodule

`default_nettype wire

@@ tb/raycast_column_marcher_tb.sv @@
`default_nettype none

module raycast_column_marcher_tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 750;
  localparam int CALM_FROM    = 650;
  localparam int HOLD_AFTER   = 100;
  localparam int HOLD_CYCLES  = 2000;
  localparam int TAIL_CYCLES  = 300;

  // One wall slice as the result channel carries it.
  typedef struct packed {
    logic [rcm_pkg::COL_W-1:0]  column;
    logic [rcm_pkg::STEP_W-1:0] steps;
    logic [rcm_pkg::ROW_W-1:0]  top;
    logic [rcm_pkg::ROW_W-1:0]  bottom;
    logic                       miss;
  } slice_t;

  // Casts rays from its own copy of the view and maze, and matches the results in order.
  class slice_board;
    logic [rcm_pkg::POS_W-1:0] pos_x;
    logic [rcm_pkg::POS_W-1:0] pos_y;
    logic [rcm_pkg::ANG_W-1:0] heading;
    logic [rcm_pkg::ANG_W-1:0] view_span;
    int               quarter_wave [rcm_pkg::SINE_N];
    logic [15:0]      maze [16];
    slice_t           pending_slices [$];
    int               mismatches;
    int               strays;
    int               reports;

    function new();
      pos_x     = rcm_pkg::PLAYER_X_RST;
      pos_y     = rcm_pkg::PLAYER_Y_RST;
      heading   = rcm_pkg::ANGLE_RST;
      view_span = rcm_pkg::FOV_RST;
      maze = '{16'hFFFF, 16'h8001, 16'h8001, 16'h8061, 16'h8061, 16'h8001, 16'h8001,
               16'h8181, 16'h8181, 16'h8001, 16'h8001, 16'h8221, 16'h8221, 16'h8001,
               16'h8001, 16'hFFFF};
      for (int k = 0; k < rcm_pkg::SINE_N; k++) begin
        quarter_wave[k] = wave_point(k);
      end
      mismatches = 0;
      strays     = 0;
      reports    = 0;
    endfunction

    // sin(k*pi/2048) in Q1.14, summed as a Q30 power series and rounded.
    function int wave_point(int k);
      longint unsigned arg;
      longint unsigned arg_sq;
      longint unsigned term;
      longint          acc;
      arg    = (64'(k) * rcm_pkg::PI_Q30) / 64'd2048;
      arg_sq = (arg * arg) >> 30;
      term   = arg;
      acc    = 0;
      for (int i = 0; i < 14; i++) begin
        if (i % 2 == 0) begin
          acc = acc + longint'(term);
        end else begin
          acc = acc - longint'(term);
        end
        term = (term * arg_sq) >> 30;
        term = term / 64'((2 * i + 2) * (2 * i + 3));
      end
      if (acc < 0) begin
        acc = 0;
      end
      return int'((acc + 32768) >> 16);
    endfunction

    function void set_reg(logic [1:0] idx, logic [rcm_pkg::PDATA_W-1:0] word);
      case (idx)
        rcm_pkg::REG_PLAYER_X:     pos_x     = word[rcm_pkg::POS_W-1:0];
        rcm_pkg::REG_PLAYER_Y:     pos_y     = word[rcm_pkg::POS_W-1:0];
        rcm_pkg::REG_PLAYER_ANGLE: heading   = word[rcm_pkg::ANG_W-1:0];
        rcm_pkg::REG_FOV:          view_span = word[rcm_pkg::ANG_W-1:0];
        default: ;
      endcase
    endfunction

    // March one ray in tenth-cell steps and derive the slice of the column.
    function slice_t cast_ray(logic [rcm_pkg::COL_W-1:0] col);
      slice_t           r;
      logic [rcm_pkg::ANG_W-1:0] dir;
      int               idx;
      int               dx;
      int               dy;
      int               n;
      int               steps;
      int               h;
      int               top;
      int               bottom;
      longint           sx;
      longint           sy;
      bit               hit;
      dir = rcm_pkg::ANG_W'(int'(heading) - int'(view_span >> 1)
                            + (int'(col) * int'(view_span)) / rcm_pkg::SCREEN_W);
      idx = int'(dir[9:0]);
      case (dir[11:10])
        2'd0: begin
          dy = quarter_wave[idx];
          dx = quarter_wave[1024 - idx];
        end
        2'd1: begin
          dy = quarter_wave[1024 - idx];
          dx = -quarter_wave[idx];
        end
        2'd2: begin
          dy = -quarter_wave[idx];
          dx = -quarter_wave[1024 - idx];
        end
        default: begin
          dy = -quarter_wave[1024 - idx];
          dx = quarter_wave[idx];
        end
      endcase

      steps = 0;
      hit   = 1'b0;
      for (n = 1; n <= rcm_pkg::MAX_STEPS; n++) begin
        sx    = longint'(pos_x) * rcm_pkg::POS_SCALE + longint'(dx) * n;
        sy    = longint'(pos_y) * rcm_pkg::POS_SCALE + longint'(dy) * n;
        steps = n;
        // A sample off the map ends the march without a wall.
        if (sx < 0 || sy < 0 || sx / rcm_pkg::POS_UNIT >= rcm_pkg::MAP_SIZE
            || sy / rcm_pkg::POS_UNIT >= rcm_pkg::MAP_SIZE) begin
          break;
        end
        if (maze[sy / rcm_pkg::POS_UNIT][sx / rcm_pkg::POS_UNIT]) begin
          hit = 1'b1;
          break;
        end
      end

      top    = 0;
      bottom = 0;
      if (hit) begin
        h      = (5 * rcm_pkg::SCREEN_H) / steps;
        top    = rcm_pkg::SCREEN_H / 2 - h / 2;
        bottom = rcm_pkg::SCREEN_H / 2 + h / 2;
        if (top < 0) begin
          top = 0;
        end
        if (bottom >= rcm_pkg::SCREEN_H) begin
          bottom = rcm_pkg::SCREEN_H - 1;
        end
      end
      r.column = col;
      r.steps  = (steps > 255) ? 8'd255 : rcm_pkg::STEP_W'(steps);
      r.top    = rcm_pkg::ROW_W'(top);
      r.bottom = rcm_pkg::ROW_W'(bottom);
      r.miss   = !hit;
      return r;
    endfunction

    function void note_column(logic [rcm_pkg::COL_W-1:0] col);
      pending_slices.push_back(cast_ray(col));
    endfunction

    function void check_slice(slice_t got);
      slice_t want;
      if (pending_slices.size() == 0) begin
        strays++;
        if (reports < 10) begin
          $display("unexpected result: column %0d steps %0d rows %0d..%0d no_hit %0b",
                   got.column, got.steps, got.top, got.bottom, got.miss);
        end
        reports++;
        return;
      end
      want = pending_slices.pop_front();
      if (got !== want) begin
        mismatches++;
        if (reports < 10) begin
          $display("slice mismatch: expected column %0d steps %0d rows %0d..%0d no_hit %0b",
                   want.column, want.steps, want.top, want.bottom, want.miss);
          $display("                actual   column %0d steps %0d rows %0d..%0d no_hit %0b",
                   got.column, got.steps, got.top, got.bottom, got.miss);
        end
        reports++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [rcm_pkg::PADDR_W-1:0]   paddr;
  logic [rcm_pkg::PDATA_W-1:0]   pwdata;
  logic [rcm_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;
  logic                          calm = 1'b0;

  int                   results_seen = 0;
  int                   hold_left    = 0;
  int                   stall_left   = 0;
  bit                   hold_done    = 1'b0;
  int                   cycle_cnt    = 0;

  slice_board           board;

  rcm_in_if  col_if ();
  rcm_out_if res_if ();

  raycast_column_marcher dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .col_i   (col_if),
    .res_o   (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: check each transaction, stall in random bursts, hold off once for long.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      board.check_slice(slice_t'{res_if.column_out, res_if.step_count, res_if.slice_top,
                                 res_if.slice_bottom, res_if.no_hit});
      results_seen <= results_seen + 1;
    end
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 39) == 0) begin
      stall_left   <= $urandom_range(0, 14);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // Offer one column; valid stays high after the transaction for the caller to reuse.
  task automatic send_column(logic [rcm_pkg::COL_W-1:0] col);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap != 0) begin
      col_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    col_if.valid  <= 1'b1;
    col_if.column <= col;
    @(posedge clk_i);
    while (!col_if.ready) @(posedge clk_i);
    board.note_column(col);
  endtask

  // Stop offering and wait until every predicted slice has come back.
  task automatic wait_drained();
    col_if.valid <= 1'b0;
    while (board.pending_slices.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Setup and access phase of one APB write; the caller closes the burst.
  task automatic write_reg(logic [1:0] idx, logic [rcm_pkg::PDATA_W-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rcm_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, word);
  endtask

  // Write the whole view; the unused upper data bits carry noise.
  task automatic load_view(logic [rcm_pkg::POS_W-1:0] px, logic [rcm_pkg::POS_W-1:0] py,
                           logic [rcm_pkg::ANG_W-1:0] ang, logic [rcm_pkg::ANG_W-1:0] span);
    write_reg(rcm_pkg::REG_PLAYER_X, {16'($urandom), px});
    write_reg(rcm_pkg::REG_PLAYER_Y, {16'($urandom), py});
    write_reg(rcm_pkg::REG_PLAYER_ANGLE, {20'($urandom), ang});
    write_reg(rcm_pkg::REG_FOV, {20'($urandom), span});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly positions inside the open area, so that rays march far.
  function automatic logic [rcm_pkg::POS_W-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return rcm_pkg::POS_W'($urandom);
      default: return rcm_pkg::POS_W'($urandom_range(4096, 61439));
    endcase
  endfunction

  function automatic logic [rcm_pkg::ANG_W-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return rcm_pkg::ANG_W'(1024 * $urandom_range(0, 3));
      default: return rcm_pkg::ANG_W'($urandom);
    endcase
  endfunction

  function automatic logic [rcm_pkg::ANG_W-1:0] pick_span();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return rcm_pkg::FOV_RST;
      default: return rcm_pkg::ANG_W'($urandom);
    endcase
  endfunction

  function automatic logic [rcm_pkg::COL_W-1:0] pick_column();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return rcm_pkg::COL_W'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int phase_len;
    board = new();
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    col_if.valid  <= 1'b0;
    col_if.column <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset view from the map center, with both bit patterns of the column.
    send_column(6'd0);
    send_column(6'd63);
    send_column(6'd21);
    send_column(6'd42);
    send_column(6'd32);

    // Player just east of the west wall, facing it: one step and a clamped slice.
    wait_drained();
    load_view(16'd4300, 16'd32768, 12'd2048, 12'd0);
    send_column(6'd0);
    send_column(6'd63);

    // Player at the far corner facing east: the first sample leaves the map.
    wait_drained();
    load_view(16'hFFFF, 16'hFFFF, 12'd0, 12'd0);
    send_column(6'd5);
    send_column(6'd60);

    // Player at the origin facing southwest: both coordinates go negative.
    wait_drained();
    load_view(16'd0, 16'd0, 12'd2560, 12'd0);
    send_column(6'd9);
    send_column(6'd54);

    // Widest field of view at the top angle, so the ray angle wraps.
    wait_drained();
    load_view(16'd32768, 16'd32768, 12'd4095, 12'd4095);
    send_column(6'd0);
    send_column(6'd1);
    send_column(6'd62);
    send_column(6'd63);

    // Rays on and around the quarter turn marks.
    wait_drained();
    load_view(16'd32768, 16'd20000, 12'd1024, 12'd0);
    send_column(6'd7);
    wait_drained();
    load_view(16'd30000, 16'd32768, 12'd3072, 12'd4095);
    send_column(6'd0);
    send_column(6'd32);
    send_column(6'd63);

    // Random views, each held for a run of random columns.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      load_view(pick_pos(), pick_pos(), pick_angle(), pick_span());
      phase_len = $urandom_range(20, 60);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        if (sent == CALM_FROM) begin
          calm <= 1'b1;
        end
        send_column(pick_column());
        sent++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.strays == 0 && board.pending_slices.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
design/rcm_pkg.sv
design/rcm_if.sv
design/rcm_ram.sv
design/raycast_column_marcher.sv
tb/raycast_column_marcher_tb.sv
